// ===== rtl/core/xrng_pkg.sv =====
// ----------------------------------------------------------------------------
// xrng_pkg
// Shared types and constants for the ranged xorshift128+ generator.
// ----------------------------------------------------------------------------
package xrng_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = DataW / 2;

  localparam logic [DataW-1:0] GoldenInc = 64'h9e3779b97f4a7c15;
  localparam logic [DataW-1:0] MixMul1   = 64'hbf58476d1ce4e5b9;
  localparam logic [DataW-1:0] MixMul2   = 64'h94d049bb133111eb;
  localparam logic [DataW-1:0] AllOnes   = {DataW{1'b1}};

  localparam int unsigned XsShl   = 23;
  localparam int unsigned XsShrX  = 18;
  localparam int unsigned XsShrY  = 5;
  localparam int unsigned MixShr1 = 30;
  localparam int unsigned MixShr2 = 27;
  localparam int unsigned MixShr3 = 31;

  localparam logic FuncNext  = 1'b0;
  localparam logic FuncRange = 1'b1;

  typedef enum logic [3:0] {
    S_MIX_A,
    S_MIX_AW,
    S_MIX_BW,
    S_IDLE,
    S_NEXT,
    S_DRAW_HI,
    S_DRAW_LO,
    S_SPLIT,
    S_LIM_GO,
    S_LIM_WAIT,
    S_CHECK,
    S_MOD_WAIT,
    S_OUT
  } xrng_state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] op_a;
    logic [DataW-1:0] op_b;
  } xrng_op_req_t;

endpackage

// ===== rtl/core/xorshift128plus_ranged_rng_top.sv =====
// ----------------------------------------------------------------------------
// xorshift128plus_ranged_rng_top
// xorshift128+ generator with plain and bounded draws, splitmix64 seeding.
//
// Input channel (in_valid_i / in_stall_o): one request per item, func_i
// picks a plain draw or a range draw over [low_bound_i, high_bound_i].
// Output channel (out_valid_o / out_stall_i): one value_o per request,
// held in an output register until taken.
// A plain draw runs S_NEXT, then S_OUT. A range draw runs S_DRAW_HI,
// S_DRAW_LO and S_SPLIT, then S_OUT for full or power-of-two spans; other
// spans run the shared restoring remainder unit twice (limit, then modulo),
// and every rejected draw is drawn again.
// One request is worked on at a time; in_stall_o stays high while busy.
// Seeding runs splitmix64 twice through one shared 32x32 multiplier after
// reset and after each seed write; requests are stalled meanwhile.
// A stalled output holds the finished value and the block waits before
// returning to idle.
// ----------------------------------------------------------------------------
module xorshift128plus_ranged_rng_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              seed_we_i,
  input  logic signed [xrng_pkg::DataW-1:0] seed_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [xrng_pkg::DataW-1:0] low_bound_i,
  input  logic signed [xrng_pkg::DataW-1:0] high_bound_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [xrng_pkg::DataW-1:0] value_o
);
  import xrng_pkg::*;

  xrng_state_e state_q, state_d;

  logic [DataW-1:0] ctr_q, word_a_q, word_b_q;
  logic             mix_sel_q;
  logic [DataW-1:0] low_q, span_q, n_q, d_q, limit_q, res_q;
  logic [HalfW-1:0] hi_q;
  logic             full_q, pow2_q, lim_done_q;
  logic             out_valid_q;
  logic [DataW-1:0] value_q;

  xrng_op_req_t     mul_req, rem_req;
  logic             mul_done, rem_done;
  logic [DataW-1:0] mul_prod, rem_val;

  logic             in_acc, out_load, out_free;
  logic [DataW-1:0] sum, xs_x, next_b, draw, mixed, span_in, span_inc;

  assign sum      = word_a_q + word_b_q;
  assign xs_x     = word_a_q ^ (word_a_q << XsShl);
  assign next_b   = xs_x ^ word_b_q ^ (xs_x >> XsShrX) ^ (word_b_q >> XsShrY);
  assign draw     = sum >> 1;
  assign mixed    = mul_prod ^ (mul_prod >> MixShr3);
  assign span_in  = DataW'(high_bound_i) - DataW'(low_bound_i);
  assign span_inc = span_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_OUT) && out_free;

  xrng_mul64lo u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  xrng_urem64 u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_MIX_A:    state_d = S_MIX_AW;
      S_MIX_AW:   if (mul_done) state_d = S_MIX_BW;
      S_MIX_BW: begin
        if (mul_done) state_d = mix_sel_q ? S_IDLE : S_MIX_A;
      end
      S_IDLE: begin
        if (in_acc) state_d = (func_i == FuncRange) ? S_DRAW_HI : S_NEXT;
      end
      S_NEXT:     state_d = S_OUT;
      S_DRAW_HI:  state_d = S_DRAW_LO;
      S_DRAW_LO:  state_d = S_SPLIT;
      S_SPLIT: begin
        if (full_q || pow2_q) begin
          state_d = S_OUT;
        end else begin
          state_d = lim_done_q ? S_CHECK : S_LIM_GO;
        end
      end
      S_LIM_GO:   state_d = S_LIM_WAIT;
      S_LIM_WAIT: if (rem_done) state_d = S_CHECK;
      S_CHECK:    state_d = (d_q > limit_q) ? S_DRAW_HI : S_MOD_WAIT;
      S_MOD_WAIT: if (rem_done) state_d = S_OUT;
      S_OUT:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
    if (seed_we_i) state_d = S_MIX_A;
  end

  always_comb begin
    in_stall_o    = (state_q != S_IDLE) || seed_we_i;
    mul_req.start = (state_q == S_MIX_A) || ((state_q == S_MIX_AW) && mul_done);
    if (state_q == S_MIX_A) begin
      mul_req.op_a = ctr_q ^ (ctr_q >> MixShr1);
      mul_req.op_b = MixMul1;
    end else begin
      mul_req.op_a = mul_prod ^ (mul_prod >> MixShr2);
      mul_req.op_b = MixMul2;
    end
    rem_req.start = (state_q == S_LIM_GO) || ((state_q == S_CHECK) && !(d_q > limit_q));
    rem_req.op_a  = (state_q == S_CHECK) ? d_q : AllOnes;
    rem_req.op_b  = n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_MIX_A;
      ctr_q       <= GoldenInc;
      mix_sel_q   <= 1'b0;
      lim_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (seed_we_i) begin
        ctr_q     <= DataW'(seed_i) + GoldenInc;
        mix_sel_q <= 1'b0;
      end else if ((state_q == S_MIX_BW) && mul_done && !mix_sel_q) begin
        ctr_q     <= ctr_q + GoldenInc;
        mix_sel_q <= 1'b1;
      end
      if (in_acc) begin
        lim_done_q <= 1'b0;
      end else if ((state_q == S_LIM_WAIT) && rem_done) begin
        lim_done_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_MIX_BW) && mul_done) begin
      if (mix_sel_q) begin
        word_b_q <= mixed;
      end else begin
        word_a_q <= mixed;
      end
    end
    if ((state_q == S_NEXT) || (state_q == S_DRAW_HI) || (state_q == S_DRAW_LO)) begin
      word_a_q <= word_b_q;
      word_b_q <= next_b;
    end
    if (in_acc) begin
      low_q  <= DataW'(low_bound_i);
      span_q <= span_in;
    end
    case (state_q)
      S_NEXT: res_q <= draw;
      S_DRAW_HI: begin
        hi_q   <= draw[HalfW-1:0];
        full_q <= &span_q;
        pow2_q <= (span_inc & span_q) == '0;
        n_q    <= span_inc;
      end
      S_DRAW_LO: d_q <= {hi_q, {HalfW{1'b0}}} | draw;
      S_SPLIT: begin
        if (full_q) begin
          res_q <= d_q + low_q;
        end else begin
          res_q <= (d_q & span_q) + low_q;
        end
      end
      S_LIM_WAIT: if (rem_done) limit_q <= ~rem_val - 1'b1;
      S_MOD_WAIT: if (rem_done) res_q <= rem_val + low_q;
      default: res_q <= res_q;
    endcase
    if (out_load) value_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

// ===== rtl/core/xrng_mul64lo.sv =====
// ----------------------------------------------------------------------------
// xrng_mul64lo
// Low half of a 64x64 product from one 32x32 multiplier, partial products in turn.
// ----------------------------------------------------------------------------
module xrng_mul64lo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  xrng_pkg::xrng_op_req_t     req_i,
  output logic                       done_o,
  output logic [xrng_pkg::DataW-1:0] prod_o
);
  import xrng_pkg::*;

  logic [DataW-1:0] a_q, b_q, pp_q, acc_q;
  logic [1:0]       cnt_q;
  logic             busy_q, done_q;
  logic [HalfW-1:0] op_a, op_b;
  logic [DataW-1:0] mult;
  logic [DataW-1:0] pp_shl;

  assign op_a   = (cnt_q == 2'd2) ? a_q[DataW-1:HalfW] : a_q[HalfW-1:0];
  assign op_b   = (cnt_q == 2'd1) ? b_q[DataW-1:HalfW] : b_q[HalfW-1:0];
  assign mult   = {{HalfW{1'b0}}, op_a} * {{HalfW{1'b0}}, op_b};
  assign pp_shl = {pp_q[HalfW-1:0], {HalfW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
    end else if (busy_q) begin
      pp_q <= mult;
      case (cnt_q)
        2'd0:    acc_q <= acc_q;
        2'd1:    acc_q <= pp_q;
        default: acc_q <= acc_q + pp_shl;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/xrng_urem64.sv =====
// ----------------------------------------------------------------------------
// xrng_urem64
// Unsigned 64-bit remainder, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xrng_urem64 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  xrng_pkg::xrng_op_req_t     req_i,
  output logic                       done_o,
  output logic [xrng_pkg::DataW-1:0] rem_o
);
  import xrng_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic [DataW-1:0] dvd_q, div_q, rem_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW:0]   trial, diff;

  assign trial = {rem_q, dvd_q[DataW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DataW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.op_a;
      div_q <= req_i.op_b;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DataW-2:0], 1'b0};
      if (!diff[DataW]) begin
        rem_q <= diff[DataW-1:0];
      end else begin
        rem_q <= trial[DataW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== test/xorshift128plus_ranged_rng_top_tb.sv =====
// ----------------------------------------------------------------------------
// xorshift128plus_ranged_rng_top_tb
// Checks plain and bounded draws of the ranged xorshift128+ generator against
// a behavioural copy of the generator kept in step with every request and seed
// write. Directed requests cover bound extremes, full, power-of-two, reversed
// and rejection-heavy spans; random phases follow under several seeds with
// bursty requests and a stalling receiver, each switched on or off per phase.
// ----------------------------------------------------------------------------
module xorshift128plus_ranged_rng_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import xrng_pkg::*;

  localparam int QuietLimit = 4000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    seed_we_i;
  logic signed [DataW-1:0] seed_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    func_i;
  logic signed [DataW-1:0] low_bound_i;
  logic signed [DataW-1:0] high_bound_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [DataW-1:0] value_o;

  logic [DataW-1:0] gen_a;
  logic [DataW-1:0] gen_b;
  logic [DataW-1:0] exp_values[$];
  int               err_count = 0;
  int               burst_left = 0;
  int               stall_run = 0;
  int               quiet_cycles;
  bit               tx_gaps_en = 1'b1;
  bit               rx_stall_en = 1'b1;

  xorshift128plus_ranged_rng_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_we_i   (seed_we_i),
    .seed_i      (seed_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .low_bound_i (low_bound_i),
    .high_bound_i(high_bound_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [DataW-1:0] splitmix_out(logic [DataW-1:0] ctr);
    logic [DataW-1:0] z;
    z = ctr;
    z = (z ^ (z >> MixShr1)) * MixMul1;
    z = (z ^ (z >> MixShr2)) * MixMul2;
    return z ^ (z >> MixShr3);
  endfunction

  function automatic void reload_generator(logic [DataW-1:0] seed_val);
    gen_a = splitmix_out(seed_val + GoldenInc);
    gen_b = splitmix_out(seed_val + GoldenInc + GoldenInc);
  endfunction

  function automatic logic [DataW-1:0] step_generator();
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] sum;
    x = gen_a;
    y = gen_b;
    sum = x + y;
    gen_a = y;
    x = x ^ (x << XsShl);
    gen_b = x ^ y ^ (x >> XsShrX) ^ (y >> XsShrY);
    return sum >> 1;
  endfunction

  function automatic logic [DataW-1:0] wide_sample();
    logic [DataW-1:0] upper;
    logic [DataW-1:0] lower;
    upper = step_generator();
    lower = step_generator();
    return (upper << HalfW) | lower;
  endfunction

  function automatic logic [DataW-1:0] predict_draw(logic f, logic [DataW-1:0] lo,
                                                    logic [DataW-1:0] hi);
    logic [DataW-1:0] span;
    logic [DataW-1:0] n;
    logic [DataW-1:0] d;
    logic [DataW-1:0] limit;
    if (f == FuncNext) begin
      return step_generator();
    end
    span = hi - lo;
    d = wide_sample();
    if (span == AllOnes) begin
      return d + lo;
    end
    n = span + 1;
    if ((n & span) == '0) begin
      return (d & span) + lo;
    end
    limit = AllOnes - (AllOnes % n) - 1;
    while (d > limit) begin
      d = wide_sample();
    end
    return (d % n) + lo;
  endfunction

  always @(posedge clk_i) begin
    logic [DataW-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_values.size() == 0) begin
          $display("%0t: unexpected value, expected none, got %h", $time, value_o);
          err_count++;
        end else begin
          want = exp_values.pop_front();
          if (value_o !== want) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, want, value_o);
            err_count++;
          end
        end
      end
      if (seed_we_i) begin
        reload_generator(seed_i);
      end
      if (in_valid_i && !in_stall_o) begin
        exp_values.push_back(predict_draw(func_i, low_bound_i, high_bound_i));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rx_stall_en) begin
      out_stall_i <= 1'b0;
    end else if (stall_run == 0) begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run <= $urandom_range(1, 12);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || seed_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(input logic f, input logic [DataW-1:0] lo,
                              input logic [DataW-1:0] hi);
    func_i       <= f;
    low_bound_i  <= lo;
    high_bound_i <= hi;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (tx_gaps_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_valid_i   <= 1'b0;
        func_i       <= 1'($urandom_range(0, 1));
        low_bound_i  <= {$urandom(), $urandom()};
        high_bound_i <= {$urandom(), $urandom()};
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_seed(input logic [DataW-1:0] seed_val);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_values.size() != 0 || in_stall_o || out_valid_o);
    seed_i    <= seed_val;
    seed_we_i <= 1'b1;
    @(posedge clk_i);
    seed_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    repeat (3) send_request(FuncNext, '0, '0);
  endtask

  task automatic test_next_ignores_bounds();
    write_seed(64'h8000_0000_0000_0000);
    send_request(FuncNext, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    send_request(FuncNext, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000);
    send_request(FuncNext, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
  endtask

  task automatic test_range_spans();
    write_seed(64'h7fff_ffff_ffff_ffff);
    // full span, in order and wrapped
    send_request(FuncRange, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    send_request(FuncRange, 64'd5, 64'd4);
    // single-value spans
    send_request(FuncRange, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_request(FuncRange, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
    // power-of-two spans
    send_request(FuncRange, -64'sd8, 64'sd7);
    send_request(FuncRange, 64'd0, 64'h7fff_ffff_ffff_ffff);
    send_request(FuncRange, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff);
    send_request(FuncRange, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
    // odd spans and reversed bounds
    send_request(FuncRange, 64'd0, 64'd2);
    send_request(FuncRange, -64'sd100, 64'sd100);
    send_request(FuncRange, 64'd10, 64'd3);
    // spans just over half the space, rejecting about half the draws
    send_request(FuncRange, 64'd0, 64'h8000_0000_0000_0000);
    send_request(FuncRange, 64'd0, 64'h8000_0000_0000_0000);
    send_request(FuncRange, 64'h8000_0000_0000_0000, 64'd0);
    send_request(FuncRange, 64'h8000_0000_0000_0000, 64'd0);
  endtask

  task automatic test_random_draws(input int count, input logic [DataW-1:0] seed_val,
                                   input bit gaps, input bit stalls);
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic             f;
    write_seed(seed_val);
    tx_gaps_en  = gaps;
    rx_stall_en = stalls;
    for (int i = 0; i < count; i++) begin
      lo = {$urandom(), $urandom()};
      hi = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          hi = lo + $urandom_range(2, 1000);
        end
        3: begin
          lo = 64'($signed($urandom_range(0, 200)) - 100);
          hi = lo + $urandom_range(0, 300);
        end
        4: begin
          hi = lo + ((64'h1 << $urandom_range(0, 63)) - 1);
        end
        5: begin
          hi = lo - 1;
        end
        6: begin
          hi = lo + 64'h8000_0000_0000_0000 + $urandom_range(0, 1 << 20);
        end
        7: begin
          hi = lo - $urandom_range(2, 1000);
        end
        default: begin
        end
      endcase
      f = ($urandom_range(0, 9) < 3) ? FuncNext : FuncRange;
      send_request(f, lo, hi);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    seed_we_i    = 1'b0;
    seed_i       = '0;
    in_valid_i   = 1'b0;
    func_i       = FuncNext;
    low_bound_i  = '0;
    high_bound_i = '0;
    reload_generator('0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_next_ignores_bounds();
    test_range_spans();
    test_random_draws(100, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1);
    test_random_draws(100, 64'h0, 1'b0, 1'b0);
    test_random_draws(100, {$urandom(), $urandom()}, 1'b1, 1'b0);
    test_random_draws(100, {$urandom(), $urandom()}, 1'b0, 1'b1);
    test_random_draws(100, 64'h1, 1'b1, 1'b1);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_values.size() != 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && exp_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
